// ===== rtl/csma_tx_pkg.sv =====
// Shared types, codes and helpers for the CSMA-CA transmit controller.
package csma_tx_pkg;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] tx_length;
    logic [7:0] frame_control;
    logic [7:0] sequence_req;
    logic [7:0] retries;
    logic       tx_done;
    logic [6:0] rx_length;
    logic       rx_crc_ok;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  backoff_periods;
    logic [1:0]  status;
    logic [7:0]  attempts;
    logic [15:0] retx_total;
    logic [15:0] noack_total;
    logic        last;
  } out_req_t;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_OUTCOME = 2'd1;
  localparam logic [1:0] OP_RX      = 2'd2;
  localparam logic [1:0] OP_TIMEOUT = 2'd3;

  localparam logic [2:0] KIND_ATTEMPT = 3'd0;
  localparam logic [2:0] KIND_BACKOFF = 3'd1;
  localparam logic [2:0] KIND_AWAIT   = 3'd2;
  localparam logic [2:0] KIND_FORWARD = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ATTEMPT = 2'd1;
  localparam logic [1:0] PH_ACKWAIT = 2'd2;

  localparam logic REG_CCA_MODE = 1'b0;
  localparam logic REG_RNG_SEED = 1'b1;

  localparam logic [15:0] LFSR_DEFAULT   = 16'hACE1;
  localparam logic [7:0]  MAX_TX_LEN     = 8'd125;
  localparam int          ACK_REQ_BIT    = 5;
  localparam logic [2:0]  FTYPE_ACK      = 3'd2;
  localparam logic [6:0]  MIN_RX_LEN     = 7'd2;
  localparam logic [6:0]  MIN_ACK_LEN    = 7'd5;
  localparam logic [7:0]  PERIODS_MAX    = 8'd31;
  localparam logic [7:0]  ATTEMPT_SAT    = 8'hFF;

  function automatic logic [15:0] xorshift16(input logic [15:0] s);
    logic [15:0] x;
    x = s;
    x = x ^ (x << 7);
    x = x ^ (x >> 9);
    x = x ^ (x << 8);
    return x;
  endfunction

endpackage

// ===== rtl/csma_ca_transmit_controller_core.sv =====
// CSMA-CA transmit sequencer: event decode, state update and result queue.
// Results of an accepted request are registered in the result queue; out_ shows its head.
// Throughput: one request per cycle while in_stall is low; a request with two
// results takes two queue entries. A 4-entry result queue sets this: in_stall
// rises while more than two results are held.
// Reset: synchronous active-low rst_n clears state and queue; no clearing pass.
module csma_ca_transmit_controller_core
  import csma_tx_pkg::*;
#(
  parameter int MAX_FRAME_RETRIES = 3,
  parameter int MAX_BACKOFFS      = 4,
  parameter int MIN_EXPONENT      = 3,
  parameter int MAX_EXPONENT      = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_req_t    out_data
);

  localparam int FIFO_DEPTH = 4;

  logic        cca_mode_r;
  logic [1:0]  phase_r, phase_nxt;
  logic        request_cca_r, request_cca_nxt;
  logic [2:0]  frame_try_r, frame_try_nxt;
  logic [2:0]  backoff_index_r, backoff_index_nxt;
  logic [3:0]  backoff_exponent_r, backoff_exponent_nxt;
  logic [7:0]  attempt_total_r, attempt_total_nxt;
  logic [7:0]  attempt_limit_r, attempt_limit_nxt;
  logic        want_ack_r, want_ack_nxt;
  logic [7:0]  expected_seq_r, expected_seq_nxt;
  logic [15:0] lfsr_r, lfsr_nxt;
  logic [15:0] retx_count_r, retx_count_nxt;
  logic [15:0] noack_count_r, noack_count_nxt;

  out_req_t    fifo_r [FIFO_DEPTH];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  count_r, count_nxt;

  logic        in_acc, out_acc;
  logic [1:0]  push_cnt;
  logic [2:0]  k0, k1;
  logic [4:0]  p0;
  logic [1:0]  s0, s1;
  out_req_t    res0, res1;
  logic [15:0] rnd_x;
  logic [8:0]  mask9;
  logic [7:0]  periods8;
  logic [4:0]  periods;
  logic        ack_match;

  assign in_stall  = (count_r > 3'd2);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (count_r != 3'd0);
  assign out_acc   = out_valid && !out_stall;
  assign out_data  = fifo_r[rd_ptr_r];

  assign rnd_x    = xorshift16(lfsr_r);
  assign mask9    = (9'd1 << backoff_exponent_r) - 9'd1;
  assign periods8 = rnd_x[7:0] & mask9[7:0];
  assign periods  = (periods8 > PERIODS_MAX) ? PERIODS_MAX[4:0] : periods8[4:0];

  assign ack_match = (phase_r == PH_ACKWAIT) && (in_data.rx_length >= MIN_ACK_LEN) &&
                     (in_data.frame_control[2:0] == FTYPE_ACK) && in_data.rx_crc_ok &&
                     (in_data.sequence_req == expected_seq_r);

  always_comb begin
    phase_nxt            = phase_r;
    request_cca_nxt      = request_cca_r;
    frame_try_nxt        = frame_try_r;
    backoff_index_nxt    = backoff_index_r;
    backoff_exponent_nxt = backoff_exponent_r;
    attempt_total_nxt    = attempt_total_r;
    attempt_limit_nxt    = attempt_limit_r;
    want_ack_nxt         = want_ack_r;
    expected_seq_nxt     = expected_seq_r;
    lfsr_nxt             = lfsr_r;
    retx_count_nxt       = retx_count_r;
    noack_count_nxt      = noack_count_r;
    push_cnt             = 2'd0;
    k0                   = KIND_ATTEMPT;
    k1                   = KIND_ATTEMPT;
    p0                   = 5'd0;
    s0                   = ST_OK;
    s1                   = ST_OK;
    if (in_acc) begin
      case (in_data.opcode)
        OP_START: begin
          if (phase_r == PH_IDLE) begin
            attempt_total_nxt = 8'd0;
            push_cnt          = 2'd1;
            if (in_data.tx_length > MAX_TX_LEN) begin
              k0 = KIND_DONE;
              s0 = ST_BAD_LEN;
            end else begin
              request_cca_nxt      = cca_mode_r;
              want_ack_nxt         = in_data.frame_control[ACK_REQ_BIT];
              expected_seq_nxt     = in_data.sequence_req;
              attempt_limit_nxt    = in_data.retries + 8'd1;
              frame_try_nxt        = 3'd0;
              backoff_index_nxt    = 3'd0;
              backoff_exponent_nxt = 4'(MIN_EXPONENT);
              phase_nxt            = PH_ATTEMPT;
              if (!cca_mode_r && (attempt_limit_nxt == 8'd0)) begin
                phase_nxt = PH_IDLE;
                k0        = KIND_DONE;
                s0        = ST_FAIL;
              end
            end
          end
        end
        OP_OUTCOME: begin
          if (phase_r == PH_ATTEMPT) begin
            if (attempt_total_r != ATTEMPT_SAT) begin
              attempt_total_nxt = attempt_total_r + 8'd1;
            end
            push_cnt = 2'd1;
            if (!request_cca_r) begin
              if (in_data.tx_done) begin
                phase_nxt = PH_IDLE;
                k0        = KIND_DONE;
              end else if (attempt_total_nxt >= attempt_limit_r) begin
                phase_nxt = PH_IDLE;
                k0        = KIND_DONE;
                s0        = ST_FAIL;
              end
            end else if (in_data.tx_done) begin
              if (!want_ack_r) begin
                phase_nxt = PH_IDLE;
                k0        = KIND_DONE;
              end else begin
                phase_nxt = PH_ACKWAIT;
                k0        = KIND_AWAIT;
              end
            end else begin
              lfsr_nxt = (rnd_x != 16'd0) ? rnd_x : LFSR_DEFAULT;
              push_cnt = 2'd2;
              k0       = KIND_BACKOFF;
              p0       = periods;
              if (backoff_index_r >= 3'(MAX_BACKOFFS)) begin
                phase_nxt = PH_IDLE;
                k1        = KIND_DONE;
                s1        = ST_FAIL;
              end else begin
                backoff_index_nxt = backoff_index_r + 3'd1;
                if (backoff_exponent_r < 4'(MAX_EXPONENT)) begin
                  backoff_exponent_nxt = backoff_exponent_r + 4'd1;
                end
              end
            end
          end
        end
        OP_RX: begin
          if (in_data.rx_length >= MIN_RX_LEN) begin
            push_cnt = 2'd1;
            if (ack_match) begin
              if (frame_try_r != 3'd0) begin
                retx_count_nxt = retx_count_r + 16'd1;
              end
              phase_nxt = PH_IDLE;
              k0        = KIND_DONE;
            end else begin
              k0 = KIND_FORWARD;
            end
          end
        end
        OP_TIMEOUT: begin
          if (phase_r == PH_ACKWAIT) begin
            push_cnt = 2'd1;
            if (frame_try_r >= 3'(MAX_FRAME_RETRIES)) begin
              noack_count_nxt = noack_count_r + 16'd1;
              phase_nxt       = PH_IDLE;
              k0              = KIND_DONE;
              s0              = ST_FAIL;
            end else begin
              frame_try_nxt        = frame_try_r + 3'd1;
              backoff_index_nxt    = 3'd0;
              backoff_exponent_nxt = 4'(MIN_EXPONENT);
              phase_nxt            = PH_ATTEMPT;
            end
          end
        end
        default: begin
          push_cnt = 2'd0;
        end
      endcase
    end

    res0.kind            = k0;
    res0.backoff_periods = p0;
    res0.status          = s0;
    res0.attempts        = attempt_total_nxt;
    res0.retx_total      = retx_count_nxt;
    res0.noack_total     = noack_count_nxt;
    res0.last            = (push_cnt == 2'd1);
    res1.kind            = k1;
    res1.backoff_periods = 5'd0;
    res1.status          = s1;
    res1.attempts        = attempt_total_nxt;
    res1.retx_total      = retx_count_nxt;
    res1.noack_total     = noack_count_nxt;
    res1.last            = 1'b1;

    count_nxt = count_r + {1'b0, push_cnt} - {2'b00, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cca_mode_r         <= 1'b0;
      phase_r            <= PH_IDLE;
      request_cca_r      <= 1'b0;
      frame_try_r        <= 3'd0;
      backoff_index_r    <= 3'd0;
      backoff_exponent_r <= 4'(MIN_EXPONENT);
      attempt_total_r    <= 8'd0;
      attempt_limit_r    <= 8'd0;
      want_ack_r         <= 1'b0;
      expected_seq_r     <= 8'd0;
      lfsr_r             <= LFSR_DEFAULT;
      retx_count_r       <= 16'd0;
      noack_count_r      <= 16'd0;
      wr_ptr_r           <= 2'd0;
      rd_ptr_r           <= 2'd0;
      count_r            <= 3'd0;
    end else begin
      phase_r            <= phase_nxt;
      request_cca_r      <= request_cca_nxt;
      frame_try_r        <= frame_try_nxt;
      backoff_index_r    <= backoff_index_nxt;
      backoff_exponent_r <= backoff_exponent_nxt;
      attempt_total_r    <= attempt_total_nxt;
      attempt_limit_r    <= attempt_limit_nxt;
      want_ack_r         <= want_ack_nxt;
      expected_seq_r     <= expected_seq_nxt;
      retx_count_r       <= retx_count_nxt;
      noack_count_r      <= noack_count_nxt;
      wr_ptr_r           <= wr_ptr_r + push_cnt;
      rd_ptr_r           <= rd_ptr_r + {1'b0, out_acc};
      count_r            <= count_nxt;
      if (cfg_we && (cfg_index == REG_CCA_MODE)) begin
        cca_mode_r <= cfg_wdata[0];
      end
      if (cfg_we && (cfg_index == REG_RNG_SEED)) begin
        lfsr_r <= (cfg_wdata != 16'd0) ? cfg_wdata : LFSR_DEFAULT;
      end else begin
        lfsr_r <= lfsr_nxt;
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (push_cnt == 2'd2) begin
      fifo_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_pair_is_backoff: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt == 2'd2) |-> (res0.kind == KIND_BACKOFF && !res0.last))
    else $error("two results without a leading backoff");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (backoff_exponent_r <= 4'(MAX_EXPONENT)) || (backoff_exponent_r == 4'(MIN_EXPONENT)))
    else $error("backoff exponent out of range");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt == 2'd1 && res0.kind == KIND_DONE) |=> (phase_r == PH_IDLE))
    else $error("done reported while still busy");
`endif

endmodule

// ===== dv/csma_ca_transmit_controller_core_test.sv =====
// Self-checking testbench for the CSMA-CA transmit controller core.
module csma_ca_transmit_controller_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import csma_tx_pkg::*;

  localparam int FRAME_RETRY_LIMIT = 3;
  localparam int BACKOFF_LIMIT     = 4;
  localparam int EXP_MIN           = 3;
  localparam int EXP_MAX           = 5;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int SETTLE_CYCLES     = 4;
  localparam int NUM_PHASES        = 8;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    in_req_t     req;
    logic        reg_index;
    logic [15:0] reg_value;
    int          fixed_n;   // -1: predicted, else count of typed results
    out_req_t    fixed;
  } step_t;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  logic     cfg_index;
  logic [15:0] cfg_wdata;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_data;

  csma_ca_transmit_controller_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // sequencer state as seen by the checker
  logic        mode_cca     = 1'b0;
  logic [1:0]  cur_phase    = PH_IDLE;
  logic        req_cca      = 1'b0;
  logic [2:0]  try_count    = '0;
  logic [2:0]  backoff_cnt  = '0;
  logic [3:0]  exponent     = 4'(EXP_MIN);
  logic [7:0]  attempt_cnt  = '0;
  logic [7:0]  attempt_max  = '0;
  logic        ack_wanted   = 1'b0;
  logic [7:0]  seq_wanted   = '0;
  logic [15:0] rng          = LFSR_DEFAULT;
  logic [15:0] retx_cnt     = '0;
  logic [15:0] noack_cnt    = '0;

  out_req_t pending_results[$];
  step_t    steps[$];
  int       errors    = 0;
  int       cycles    = 0;
  int       hold_left = 0;
  logic     calm      = 1'b0;
  logic     marathon  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void expect_result(logic [2:0] kind, int periods, logic [1:0] status,
                                        logic last);
    pending_results.push_back(out_req_t'{kind, periods[4:0], status, attempt_cnt, retx_cnt,
                                         noack_cnt, last});
  endfunction

  function automatic int step_sequencer(in_req_t r);
    int          before_n;
    int          periods;
    int          exp_used;
    logic [15:0] x;
    before_n = pending_results.size();
    case (r.opcode)
      OP_START: begin
        if (cur_phase == PH_IDLE) begin
          attempt_cnt = '0;
          if (r.tx_length > MAX_TX_LEN) begin
            expect_result(KIND_DONE, 0, ST_BAD_LEN, 1'b1);
          end else begin
            req_cca     = mode_cca;
            ack_wanted  = r.frame_control[ACK_REQ_BIT];
            seq_wanted  = r.sequence_req;
            attempt_max = r.retries + 8'd1;
            try_count   = '0;
            backoff_cnt = '0;
            exponent    = 4'(EXP_MIN);
            cur_phase   = PH_ATTEMPT;
            if (!req_cca && attempt_max == 8'd0) begin
              cur_phase = PH_IDLE;
              expect_result(KIND_DONE, 0, ST_FAIL, 1'b1);
            end else begin
              expect_result(KIND_ATTEMPT, 0, ST_OK, 1'b1);
            end
          end
        end
      end
      OP_OUTCOME: begin
        if (cur_phase == PH_ATTEMPT) begin
          if (attempt_cnt != ATTEMPT_SAT) attempt_cnt++;
          if (!req_cca) begin
            if (r.tx_done) begin
              cur_phase = PH_IDLE;
              expect_result(KIND_DONE, 0, ST_OK, 1'b1);
            end else if (attempt_cnt >= attempt_max) begin
              cur_phase = PH_IDLE;
              expect_result(KIND_DONE, 0, ST_FAIL, 1'b1);
            end else begin
              expect_result(KIND_ATTEMPT, 0, ST_OK, 1'b1);
            end
          end else if (r.tx_done) begin
            if (!ack_wanted) begin
              cur_phase = PH_IDLE;
              expect_result(KIND_DONE, 0, ST_OK, 1'b1);
            end else begin
              cur_phase = PH_ACKWAIT;
              expect_result(KIND_AWAIT, 0, ST_OK, 1'b1);
            end
          end else begin
            x = rng;
            x = x ^ (x << 7);
            x = x ^ (x >> 9);
            x = x ^ (x << 8);
            rng = (x != 16'd0) ? x : LFSR_DEFAULT;
            exp_used = (exponent > 8) ? 8 : exponent;
            periods = int'(x[7:0]) & ((1 << exp_used) - 1);
            if (periods > 31) periods = 31;
            if (backoff_cnt >= BACKOFF_LIMIT) begin
              expect_result(KIND_BACKOFF, periods, ST_OK, 1'b0);
              cur_phase = PH_IDLE;
              expect_result(KIND_DONE, 0, ST_FAIL, 1'b1);
            end else begin
              backoff_cnt++;
              if (exponent < EXP_MAX) exponent++;
              expect_result(KIND_BACKOFF, periods, ST_OK, 1'b0);
              expect_result(KIND_ATTEMPT, 0, ST_OK, 1'b1);
            end
          end
        end
      end
      OP_RX: begin
        if (r.rx_length >= MIN_RX_LEN) begin
          if (cur_phase == PH_ACKWAIT && r.rx_length >= MIN_ACK_LEN &&
              r.frame_control[2:0] == FTYPE_ACK && r.rx_crc_ok &&
              r.sequence_req == seq_wanted) begin
            if (try_count > 0) retx_cnt++;
            cur_phase = PH_IDLE;
            expect_result(KIND_DONE, 0, ST_OK, 1'b1);
          end else begin
            expect_result(KIND_FORWARD, 0, ST_OK, 1'b1);
          end
        end
      end
      default: begin
        if (cur_phase == PH_ACKWAIT) begin
          if (try_count >= FRAME_RETRY_LIMIT) begin
            noack_cnt++;
            cur_phase = PH_IDLE;
            expect_result(KIND_DONE, 0, ST_FAIL, 1'b1);
          end else begin
            try_count++;
            backoff_cnt = '0;
            exponent    = 4'(EXP_MIN);
            cur_phase   = PH_ATTEMPT;
            expect_result(KIND_ATTEMPT, 0, ST_OK, 1'b1);
          end
        end
      end
    endcase
    return pending_results.size() - before_n;
  endfunction

  // mostly well-formed events for the current phase, some noise
  function automatic in_req_t make_request();
    logic [63:0] raw;
    in_req_t     r;
    int          pick;
    raw  = {$urandom, $urandom};
    r    = raw[$bits(in_req_t)-1:0];
    pick = $urandom_range(99);
    if (pick >= 90 && !marathon) return r;
    case (cur_phase)
      PH_IDLE: begin
        r.opcode = OP_START;
        if (pick < 80 || marathon) r.tx_length = 8'($urandom_range(125));
        if (marathon) r.retries = 8'd254;
        else if (!mode_cca && pick < 70) r.retries = 8'($urandom_range(4));
        else if (!mode_cca && pick < 74) r.retries = 8'hFF;
        if (mode_cca && pick < 70) r.frame_control[ACK_REQ_BIT] = 1'b1;
      end
      PH_ATTEMPT: begin
        r.opcode  = (pick < 8) ? OP_RX : OP_OUTCOME;
        r.tx_done = marathon ? 1'b0 : ($urandom_range(99) < 35);
      end
      PH_ACKWAIT: begin
        if (pick < 30) begin
          r.opcode             = OP_RX;
          r.rx_length          = 7'($urandom_range(MIN_ACK_LEN, 127));
          r.frame_control[2:0] = FTYPE_ACK;
          r.rx_crc_ok          = 1'b1;
          r.sequence_req       = seq_wanted;
        end else if (pick < 45) begin
          r.opcode = OP_RX;
        end else begin
          r.opcode = OP_TIMEOUT;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic step_t request_row(logic [1:0] op, logic [7:0] txlen, logic [7:0] fc,
                                        logic [7:0] seq, logic [7:0] retries, logic done,
                                        logic [6:0] rxlen, logic crc, int fixed_n = -1,
                                        out_req_t fixed = '0);
    step_t s;
    s.kind      = ROW_REQUEST;
    s.req       = in_req_t'{op, txlen, fc, seq, retries, done, rxlen, crc};
    s.reg_index = REG_CCA_MODE;
    s.reg_value = '0;
    s.fixed_n   = fixed_n;
    s.fixed     = fixed;
    return s;
  endfunction

  function automatic step_t write_row(logic idx, logic [15:0] value);
    step_t s;
    s           = request_row(OP_START, 0, 0, 0, 0, 0, 0, 0);
    s.kind      = ROW_WRITE;
    s.reg_index = idx;
    s.reg_value = value;
    return s;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
  endtask

  task automatic send_request(in_req_t r, int fixed_n, out_req_t fixed, output int produced);
    int gap;
    gap = (!calm && $urandom_range(99) < 8) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    produced = step_sequencer(r);
    if (fixed_n >= 0) begin
      repeat (produced) void'(pending_results.pop_back());
      if (fixed_n > 0) pending_results.push_back(fixed);
      produced = fixed_n;
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CCA_MODE) mode_cca = value[0];
    else rng = (value != 16'd0) ? value : LFSR_DEFAULT;
  endtask

  // result checker
  always @(posedge clk) begin
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", out_data.kind, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind) report_mismatch("kind", out_data.kind, want.kind);
        if (out_data.backoff_periods !== want.backoff_periods)
          report_mismatch("backoff_periods", out_data.backoff_periods, want.backoff_periods);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.attempts !== want.attempts)
          report_mismatch("attempts", out_data.attempts, want.attempts);
        if (out_data.retx_total !== want.retx_total)
          report_mismatch("retx_total", out_data.retx_total, want.retx_total);
        if (out_data.noack_total !== want.noack_total)
          report_mismatch("noack_total", out_data.noack_total, want.noack_total);
        if (out_data.last !== want.last) report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  // receiver: random stalls, plus a long hold when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 8);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic        cca_plan[NUM_PHASES];
    logic [15:0] seed;
    int          quota;
    int          produced;
    int          sent;
    cca_plan  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_CCA_MODE;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // plain mode straight out of reset
    steps.push_back(request_row(OP_START, 8'd255, 0, 0, 0, 0, 0, 0, 1,
                                out_req_t'{KIND_DONE, 5'd0, ST_BAD_LEN, 8'd0, 16'd0, 16'd0, 1'b1}));
    steps.push_back(request_row(OP_START, 8'd126, 8'hFF, 8'hFF, 8'hFF, 1, 7'h7F, 1, 1,
                                out_req_t'{KIND_DONE, 5'd0, ST_BAD_LEN, 8'd0, 16'd0, 16'd0, 1'b1}));
    steps.push_back(request_row(OP_START, 8'd125, 0, 0, 8'hFF, 0, 0, 0, 1,
                                out_req_t'{KIND_DONE, 5'd0, ST_FAIL, 8'd0, 16'd0, 16'd0, 1'b1}));
    steps.push_back(request_row(OP_OUTCOME, 0, 0, 0, 0, 1, 0, 0, 0));
    steps.push_back(request_row(OP_TIMEOUT, 0, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(request_row(OP_RX, 0, FTYPE_ACK, 0, 0, 0, 7'd1, 1, 0));
    steps.push_back(request_row(OP_RX, 0, 0, 0, 0, 0, 7'd0, 0, 0));
    steps.push_back(request_row(OP_RX, 0, 8'hFF, 8'hFF, 0, 0, 7'h7F, 1, 1,
                                out_req_t'{KIND_FORWARD, 5'd0, ST_OK, 8'd0, 16'd0, 16'd0, 1'b1}));
    steps.push_back(request_row(OP_START, 8'd0, 0, 8'h5A, 8'd0, 0, 0, 0));
    steps.push_back(request_row(OP_START, 8'd1, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(request_row(OP_OUTCOME, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(request_row(OP_START, 8'd10, 8'h20, 8'd1, 8'd1, 0, 0, 0));
    steps.push_back(request_row(OP_OUTCOME, 0, 0, 0, 0, 1, 0, 0));
    // CSMA-CA: channel access exhausted, then ack after one retransmission
    steps.push_back(write_row(REG_CCA_MODE, 16'd1));
    steps.push_back(write_row(REG_RNG_SEED, 16'd0));
    steps.push_back(request_row(OP_START, 8'd125, 8'h20, 8'hFF, 8'd0, 0, 0, 0));
    repeat (5) steps.push_back(request_row(OP_OUTCOME, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(request_row(OP_START, 8'd60, 8'h21, 8'd0, 0, 0, 0, 0));
    steps.push_back(request_row(OP_OUTCOME, 0, 0, 0, 0, 1, 0, 0));
    steps.push_back(request_row(OP_TIMEOUT, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(request_row(OP_OUTCOME, 0, 0, 0, 0, 1, 0, 0));
    steps.push_back(request_row(OP_RX, 0, 8'h02, 8'd1, 0, 0, 7'd5, 1));
    steps.push_back(request_row(OP_RX, 0, 8'hFA, 8'd0, 0, 0, 7'd5, 1));

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_WRITE) begin
        settle();
        write_reg(steps[i].reg_index, steps[i].reg_value);
      end else begin
        send_request(steps[i].req, steps[i].fixed_n, steps[i].fixed, produced);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: seed = 16'h0000;
        1: seed = 16'hFFFF;
        2: seed = 16'h0001;
        3: seed = 16'h8000;
        default: seed = 16'($urandom);
      endcase
      write_reg(REG_CCA_MODE, {15'd0, cca_plan[ph]});
      write_reg(REG_RNG_SEED, seed);
      calm     = (ph == 2);
      marathon = (ph == 4);
      quota    = marathon ? 270 : 80;
      if (ph == 6) hold_left = 120;
      sent = 0;
      while (sent < quota) begin
        send_request(make_request(), -1, '0, produced);
        if (produced > 0) sent++;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never seen", pending_results.size(), 0);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
